// ----- hw/rtl/telecontrol_apci_header_decoder_top_macros.svh -----
// Assertion macros shared by the APCI header decoder RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef TELECONTROL_APCI_HEADER_DECODER_TOP_MACROS_SVH
`define TELECONTROL_APCI_HEADER_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define TCAD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TCAD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TCAD_ASSERT(label, clk, rst, prop, msg)
`define TCAD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ----- hw/rtl/tcad_pkg.sv -----
// Types and constants of the APCI header decoder.
// No dependencies; used by the core and the top level.
`timescale 1ns / 1ps

package tcad_pkg;

   localparam logic [11:0] CTRL_LEN = 12'd4;

   typedef enum logic [1:0] {
      FT_UNKNOWN = 2'd0,
      FT_INFO    = 2'd1,
      FT_SUPER   = 2'd2,
      FT_UNNUM   = 2'd3
   } frame_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_TOO_SHORT = 3'd1,
      ERR_BAD_START = 3'd2,
      ERR_LEN_SHORT = 3'd3,
      ERR_SU_LEN    = 3'd4,
      ERR_BAD_CTRL  = 3'd5
   } err_code_type;

   typedef enum logic [1:0] {
      CSR_LEN_BYTES  = 2'd0,
      CSR_SKIP_CTRL  = 2'd1,
      CSR_START_BYTE = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic           frame_ok;
      frame_kind_type frame_type;
      err_code_type   error_code;
      logic [11:0]    apdu_length;
      logic [14:0]    send_seq;
      logic [14:0]    recv_seq;
   } rsp_type;

   typedef struct packed {
      logic [1:0] length_field_bytes;
      logic       skip_control_check;
      logic [7:0] start_byte;
   } cfg_type;

endpackage

// ----- hw/rtl/tcad_chan_if.sv -----
// Valid/ready stream interface carrying one payload per beat.
// Depends on nothing; the payload type is given where it is instantiated.
`timescale 1ns / 1ps

interface tcad_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tcad_csr_if.sv -----
// Register write interface: one register index and its data per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface tcad_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/tcad_core.sv -----
// Header position tracking, frame verdict and persistent sequence numbers.
// Depends on tcad_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "telecontrol_apci_header_decoder_top_macros.svh"

module tcad_core
   import tcad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en_i,
   input  req_type in_i,
   input  cfg_type cfg_i,
   output logic    emit_o,
   output rsp_type rsp_o
);

   logic [2:0]  pos_ff, pos_in;
   logic        hd_ff, hd_in;
   logic [7:0]  start_ff, start_in;
   logic [11:0] len_ff, len_in;
   logic [7:0]  ctrl_ff [3];
   logic [7:0]  ctrl_in [3];
   logic [14:0] send_ff, send_in;
   logic [14:0] recv_ff, recv_in;

   logic        lf2;
   logic [2:0]  lf_val;
   logic [2:0]  final_pos;
   logic [2:0]  ctrl_pos;
   logic [7:0]  c1, c2, c3, c4;

   assign lf2       = cfg_i.length_field_bytes[1];
   assign lf_val    = lf2 ? 3'd2 : 3'd1;
   assign final_pos = lf2 ? 3'd6 : 3'd5;
   assign ctrl_pos  = pos_ff - 3'd1 - lf_val;
   assign c1        = ctrl_ff[0];
   assign c2        = ctrl_ff[1];
   assign c3        = ctrl_ff[2];
   assign c4        = in_i.data_byte;

   always_comb begin
      pos_in   = pos_ff;
      hd_in    = hd_ff;
      start_in = start_ff;
      len_in   = len_ff;
      ctrl_in  = ctrl_ff;
      send_in  = send_ff;
      recv_in  = recv_ff;
      emit_o   = 1'b0;

      rsp_o.frame_ok    = 1'b0;
      rsp_o.frame_type  = FT_UNKNOWN;
      rsp_o.error_code  = ERR_NONE;
      rsp_o.apdu_length = len_ff;

      if (hd_ff) begin
         if (in_i.last_byte) begin
            hd_in  = 1'b0;
            pos_in = 3'd0;
         end
      end else if (pos_ff >= final_pos) begin
         // The byte at hand is the fourth control byte.
         emit_o = 1'b1;
         pos_in = 3'd0;
         hd_in  = !in_i.last_byte;
         priority if (start_ff != cfg_i.start_byte) begin
            rsp_o.error_code = ERR_BAD_START;
         end else if (len_ff < CTRL_LEN) begin
            rsp_o.error_code = ERR_LEN_SHORT;
         end else if (cfg_i.skip_control_check) begin
            rsp_o.frame_ok   = 1'b1;
            rsp_o.frame_type = (len_ff > CTRL_LEN) ? FT_INFO : FT_UNNUM;
         end else if (!c1[0] && !c3[0]) begin
            rsp_o.frame_ok   = 1'b1;
            rsp_o.frame_type = FT_INFO;
            send_in          = {c2, c1[7:1]};
            recv_in          = {c4, c3[7:1]};
         end else if (len_ff != CTRL_LEN) begin
            rsp_o.error_code = ERR_SU_LEN;
         end else if (c1[1:0] == 2'b01 && !c3[0]) begin
            rsp_o.frame_ok   = 1'b1;
            rsp_o.frame_type = FT_SUPER;
            send_in          = 15'd0;
            recv_in          = {c4, c3[7:1]};
         end else if (c1[1:0] == 2'b11 && !c3[0]) begin
            rsp_o.frame_ok   = 1'b1;
            rsp_o.frame_type = FT_UNNUM;
            send_in          = 15'd0;
            recv_in          = 15'd0;
         end else begin
            rsp_o.error_code = ERR_BAD_CTRL;
         end
      end else begin
         priority if (pos_ff == 3'd0) begin
            start_in = in_i.data_byte;
         end else if (pos_ff == 3'd1) begin
            len_in = {4'd0, in_i.data_byte};
         end else if (pos_ff == 3'd2 && lf2) begin
            len_in = {in_i.data_byte[3:0], len_ff[7:0]};
         end else if (ctrl_pos < 3'd3) begin
            ctrl_in[ctrl_pos[1:0]] = in_i.data_byte;
         end else begin
            ctrl_in = ctrl_ff;
         end
         if (in_i.last_byte) begin
            emit_o            = 1'b1;
            pos_in            = 3'd0;
            rsp_o.error_code  = ERR_TOO_SHORT;
            rsp_o.apdu_length = 12'd0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end

      rsp_o.send_seq = send_in;
      rsp_o.recv_seq = recv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 3'd0;
         hd_ff    <= 1'b0;
         start_ff <= 8'd0;
         len_ff   <= 12'd0;
         ctrl_ff  <= '{default: 8'd0};
         send_ff  <= 15'd0;
         recv_ff  <= 15'd0;
      end else if (step_en_i) begin
         pos_ff   <= pos_in;
         hd_ff    <= hd_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         ctrl_ff  <= ctrl_in;
         send_ff  <= send_in;
         recv_ff  <= recv_in;
      end
   end

   `TCAD_ASSERT(a_done_at_zero, clock, reset, hd_ff |-> (pos_ff == 3'd0), "header done with nonzero position")
   `TCAD_ASSERT(a_pos_advance, clock, reset, (step_en_i && !hd_ff && !emit_o) |=> (pos_ff == $past(pos_ff) + 3'd1), "position did not advance")
   `TCAD_ASSERT(a_fail_keeps_seq, clock, reset, (step_en_i && emit_o && !rsp_o.frame_ok) |=> (send_ff == $past(send_ff) && recv_ff == $past(recv_ff)), "failed frame changed sequence numbers")

endmodule

// ----- hw/rtl/telecontrol_apci_header_decoder_top.sv -----
// APCI header decoder: one byte per beat in, one verdict per frame out.
// Path: input register, core, result register. Throughput: one byte per
// cycle; the input register and the result register let a new byte in
// while a verdict waits to be taken, unless the held byte has a verdict.
// Reset: synchronous, active high; clears position, sequence numbers and
// restores the registers to one length byte, control check on, start 0x68.
`timescale 1ns / 1ps
`include "telecontrol_apci_header_decoder_top_macros.svh"

module telecontrol_apci_header_decoder_top
   import tcad_pkg::*;
(
   input logic  clock,
   input logic  reset,
   tcad_chan_if.sink   req_chan,
   tcad_chan_if.source rsp_chan,
   tcad_csr_if.sink    csr_chan
);

   cfg_type cfg_ff, cfg_in;
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic    core_emit;
   rsp_type core_rsp;
   logic    out_free;
   logic    s1_fire;
   logic    req_take;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_idx_type'(csr_chan.index))
            CSR_LEN_BYTES:  cfg_in.length_field_bytes = csr_chan.data[1:0];
            CSR_SKIP_CTRL:  cfg_in.skip_control_check = csr_chan.data[0];
            CSR_START_BYTE: cfg_in.start_byte         = csr_chan.data;
            default:        cfg_in                    = cfg_ff;
         endcase
      end
   end

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && (!core_emit || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_take || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in   = (s1_fire && core_emit) || (rsp_valid_ff && !rsp_chan.ready);

   tcad_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en_i (s1_fire),
      .in_i      (s1_data_ff),
      .cfg_i     (cfg_ff),
      .emit_o    (core_emit),
      .rsp_o     (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.length_field_bytes <= 2'd1;
         cfg_ff.skip_control_check <= 1'b0;
         cfg_ff.start_byte         <= 8'h68;
         s1_valid_ff               <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_chan.payload;
      end
      if (s1_fire && core_emit) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `TCAD_ASSERT(a_ok_clean, clock, reset, (rsp_valid_ff && rsp_data_ff.frame_ok) |-> (rsp_data_ff.error_code == ERR_NONE && rsp_data_ff.frame_type != FT_UNKNOWN), "good frame with error or unknown type")
   `TCAD_ASSERT(a_fail_coded, clock, reset, (rsp_valid_ff && !rsp_data_ff.frame_ok) |-> (rsp_data_ff.error_code != ERR_NONE && rsp_data_ff.frame_type == FT_UNKNOWN), "failed frame without error code")
   `TCAD_ASSERT(a_short_no_len, clock, reset, (rsp_valid_ff && rsp_data_ff.error_code == ERR_TOO_SHORT) |-> (rsp_data_ff.apdu_length == 12'd0), "short frame with nonzero length")
   `TCAD_ASSERT_NEVER(a_s1_lost, clock, reset, s1_valid_ff && !s1_fire && !s1_valid_in, "held byte dropped from input register")

endmodule
